### rtl/rational_arithmetic_unit_top_assert.svh
// Assertion macros for the rational arithmetic unit.
// Used by the modules of the rtl folder; depends on nothing else.
`ifndef RATIONAL_ARITHMETIC_UNIT_TOP_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_TOP_ASSERT_SVH
`ifndef SYNTH
`define RAU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RAU_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/rau_pkg.sv
// Package of the rational arithmetic unit: widths, codes and state types.
// Used by every module in the rtl folder.
package rau_pkg;
    localparam int VALUE_WIDTH = 32;
    localparam int MAG_W = 64;
    localparam int CNT_W = 7;

    typedef enum logic [1:0] {
        K_ADD = 2'd0,
        K_SUB = 2'd1,
        K_MUL = 2'd2,
        K_DIV = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_OVF  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        DV_IDLE,
        DV_SHIFT,
        DV_DONE
    } t_dv_state;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GCD1,
        S_LCM,
        S_MULA,
        S_MULB,
        S_ADD,
        S_PNUM,
        S_PDEN,
        S_GCD2,
        S_RED1,
        S_RED2,
        S_CHECK,
        S_OUT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] dividend;
        logic [MAG_W-1:0] divisor;
    } t_dv_req;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] quot;
        logic [MAG_W-1:0] rem;
    } t_dv_rsp;
endpackage

### rtl/rau_divider.sv
// Shared restoring divider, one quotient bit per cycle, for 64-bit magnitudes.
// Depends on rau_pkg.
module rau_divider
    import rau_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dv_req i_req,
    output t_dv_rsp o_rsp
);
    t_dv_state        r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [MAG_W-1:0] r_q, n_q, r_r, n_r, r_d, n_d;
    logic [MAG_W:0]   w_trial;

    always_comb begin
        n_state = r_state;
        case (r_state)
            DV_IDLE:  if (i_req.start) n_state = DV_SHIFT;
            DV_SHIFT: if (r_cnt == CNT_W'(MAG_W - 1)) n_state = DV_DONE;
            DV_DONE:  n_state = DV_IDLE;
            default:  n_state = DV_IDLE;
        endcase
    end

    always_comb begin
        n_q = r_q;
        n_r = r_r;
        n_d = r_d;
        n_cnt = r_cnt;
        w_trial = {r_r, r_q[MAG_W-1]};
        case (r_state)
            DV_IDLE: begin
                n_q = i_req.dividend;
                n_r = '0;
                n_d = i_req.divisor;
                n_cnt = '0;
            end
            DV_SHIFT: begin
                n_cnt = r_cnt + 1'b1;
                if (w_trial >= {1'b0, r_d}) begin
                    n_r = MAG_W'(w_trial - {1'b0, r_d});
                    n_q = {r_q[MAG_W-2:0], 1'b1};
                end else begin
                    n_r = w_trial[MAG_W-1:0];
                    n_q = {r_q[MAG_W-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cnt <= n_cnt;
        r_q <= n_q;
        r_r <= n_r;
        r_d <= n_d;
    end

    assign o_rsp.done = (r_state == DV_DONE);
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_r;

    `include "rational_arithmetic_unit_top_assert.svh"
    `RAU_ASSERT_NEXT(a_dv_start, i_clk, i_rst_n, r_state == DV_IDLE && i_req.start, r_state == DV_SHIFT)
    `RAU_ASSERT_NEXT(a_dv_done, i_clk, i_rst_n, r_state == DV_DONE, r_state == DV_IDLE)
    `RAU_ASSERT_IMPL(a_dv_rem, i_clk, i_rst_n, r_state == DV_DONE && r_d != '0, r_r < r_d)
endmodule

### rtl/rational_arithmetic_unit_top.sv
// Top level of the rational arithmetic unit: sequencer, multiplier and divider use.
// Depends on rau_pkg and rau_divider.
//
// Channel  Dir  Handshake            Payload
// s_axis   in   tvalid/tready        kind, a_num, a_den, b_num, b_den
// m_axis   out  tvalid/tready        res_num, res_den, status
//
// Every quotient or remainder comes from the shared divider. Beside its Euclid steps
// a word takes four more divisions for add and subtract and two for multiply and
// divide; a bad operand skips them and goes straight to the output state. Reset is
// synchronous and active low and returns the sequencer to idle.
// The result register holds its word while m_axis_tready is low; no new input
// word is taken until the result has been delivered.
module rational_arithmetic_unit_top
    import rau_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,  // kind, a_num, a_den, b_num, b_den, zero fill
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata   // res_num, res_den, status, zero fill
);
    localparam logic [MAG_W-1:0] HALF = MAG_W'(1) << (VALUE_WIDTH - 1);

    t_state           r_state, n_state;
    t_kind            r_kind, w_kind_in;
    logic [MAG_W-1:0] r_an, r_ad, r_bn, r_bd;
    logic [MAG_W-1:0] r_x, r_y, r_g, r_ta, r_tb, r_num, r_den;
    logic [MAG_W-1:0] n_x, n_y, n_g, n_ta, n_tb, n_num, n_den;
    logic             r_sa, r_sb, r_neg, n_neg, r_wait, n_wait;
    logic [31:0]      r_res_num, n_res_num;
    logic [30:0]      r_res_den, n_res_den;
    t_status          r_status, n_status;
    t_dv_req          w_req;
    t_dv_rsp          w_rsp;
    logic             w_acc, w_bad, w_gcd, w_dv_use, w_dv_fin;
    logic [MAG_W-1:0] w_mul_a, w_mul_b, w_prod, w_sum;
    logic             w_sum_neg, w_sbe;
    logic [VALUE_WIDTH-1:0] w_f [4];
    logic [MAG_W-1:0] w_m [4];
    logic             w_s [4];

    rau_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata = {7'd0, r_status, r_res_den, r_res_num};
    assign w_kind_in = t_kind'(s_axis_tdata[1:0]);

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_f[i] = s_axis_tdata[2 + 32*i +: VALUE_WIDTH];
            w_s[i] = w_f[i][VALUE_WIDTH-1];
            w_m[i] = w_s[i] ? MAG_W'(-{1'b0, w_f[i]}) & ((MAG_W'(1) << VALUE_WIDTH) - 1)
                            : MAG_W'(w_f[i]);
        end
        w_bad = (w_m[1] == '0) || (w_m[3] == '0) || (w_kind_in == K_DIV && w_m[2] == '0);
    end

    assign w_gcd = (r_state inside {S_GCD1, S_GCD2});
    assign w_dv_use = (w_gcd && r_y != '0) || (r_state inside {S_LCM, S_MULA, S_RED1, S_RED2});
    assign w_dv_fin = w_dv_use && r_wait && w_rsp.done;
    assign n_wait = w_dv_use && !w_dv_fin;

    always_comb begin
        w_req.start = w_dv_use && !r_wait;
        w_req.dividend = r_x;
        w_req.divisor = r_y;
        case (r_state)
            S_LCM:  begin w_req.dividend = r_ad; w_req.divisor = r_g; end
            S_MULA: begin w_req.dividend = r_bd; w_req.divisor = r_g; end
            S_RED1: begin w_req.dividend = r_num; w_req.divisor = r_g; end
            S_RED2: begin w_req.dividend = r_den; w_req.divisor = r_g; end
            default: ;
        endcase
    end

    // Shared 32x32 product; every multiplied magnitude is at most 2^31.
    always_comb begin
        w_mul_a = r_an;
        w_mul_b = r_bn;
        case (r_state)
            S_LCM:  begin w_mul_a = w_rsp.quot; w_mul_b = r_bd; end
            S_MULA: begin w_mul_a = r_an; w_mul_b = w_rsp.quot; end
            S_MULB: begin w_mul_a = r_bn; w_mul_b = r_y; end
            S_PNUM: begin w_mul_a = r_an; w_mul_b = (r_kind == K_MUL) ? r_bn : r_bd; end
            S_PDEN: begin w_mul_a = r_ad; w_mul_b = (r_kind == K_MUL) ? r_bd : r_bn; end
            default: ;
        endcase
        w_prod = MAG_W'(w_mul_a[31:0] * w_mul_b[31:0]);
    end

    assign w_sbe = (r_kind == K_SUB) ? !r_sb : r_sb;

    always_comb begin
        if (r_sa == w_sbe) begin
            w_sum = r_ta + r_tb; w_sum_neg = r_sa;
        end else if (r_ta >= r_tb) begin
            w_sum = r_ta - r_tb; w_sum_neg = r_sa;
        end else begin
            w_sum = r_tb - r_ta; w_sum_neg = w_sbe;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_acc) begin
                if (w_bad) n_state = S_OUT;
                else if (w_kind_in inside {K_ADD, K_SUB}) n_state = S_GCD1;
                else n_state = S_PNUM;
            end
            S_GCD1:  if (r_y == '0) n_state = S_LCM;
            S_LCM:   if (w_dv_fin) n_state = S_MULA;
            S_MULA:  if (w_dv_fin) n_state = S_MULB;
            S_MULB:  n_state = S_ADD;
            S_ADD:   n_state = (w_sum == '0) ? S_CHECK : S_GCD2;
            S_PNUM:  n_state = S_PDEN;
            S_PDEN:  n_state = (r_num == '0) ? S_CHECK : S_GCD2;
            S_GCD2:  if (r_y == '0) n_state = S_RED1;
            S_RED1:  if (w_dv_fin) n_state = S_RED2;
            S_RED2:  if (w_dv_fin) n_state = S_CHECK;
            S_CHECK: n_state = S_OUT;
            S_OUT:   if (m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_x = r_x; n_y = r_y; n_g = r_g; n_ta = r_ta; n_tb = r_tb;
        n_num = r_num; n_den = r_den; n_neg = r_neg;
        n_res_num = r_res_num; n_res_den = r_res_den; n_status = r_status;
        case (r_state)
            S_IDLE: if (w_acc) begin
                n_x = w_m[1];
                n_y = w_m[3];
                n_neg = (w_s[0] != w_s[1]) != (w_s[2] != w_s[3]);
                n_res_num = '0; n_res_den = '0; n_status = ST_ZERO;
            end
            S_GCD1, S_GCD2: begin
                if (r_y == '0) begin
                    n_g = r_x;
                end else if (w_dv_fin) begin
                    n_x = r_y;
                    n_y = w_rsp.rem;
                end
            end
            S_LCM: if (w_dv_fin) begin
                n_den = w_prod;
                n_y = w_rsp.quot;
            end
            S_MULA: if (w_dv_fin) n_ta = w_prod;
            S_MULB: n_tb = w_prod;
            S_ADD: begin
                n_num = w_sum; n_neg = w_sum_neg;
                n_x = w_sum; n_y = r_den;
            end
            S_PNUM: n_num = w_prod;
            S_PDEN: begin
                n_den = w_prod; n_x = r_num; n_y = w_prod;
            end
            S_RED1: if (w_dv_fin) n_num = w_rsp.quot;
            S_RED2: if (w_dv_fin) n_den = w_rsp.quot;
            S_CHECK: begin
                if (r_num == '0) begin
                    n_res_num = '0; n_res_den = 31'd1; n_status = ST_OK;
                end else if (r_den > HALF - MAG_W'(1)
                             || (r_neg ? r_num > HALF : r_num > HALF - MAG_W'(1))) begin
                    n_res_num = '0; n_res_den = '0; n_status = ST_OVF;
                end else begin
                    n_res_num = 32'(signed'(VALUE_WIDTH'(r_neg ? -r_num : r_num)));
                    n_res_den = r_den[30:0];
                    n_status = ST_OK;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wait <= n_wait;
        end
        if (w_acc) begin
            r_kind <= w_kind_in;
            r_an <= w_m[0]; r_ad <= w_m[1]; r_bn <= w_m[2]; r_bd <= w_m[3];
            r_sa <= w_s[0] != w_s[1];
            r_sb <= w_s[2] != w_s[3];
        end
        r_x <= n_x; r_y <= n_y; r_g <= n_g; r_ta <= n_ta; r_tb <= n_tb;
        r_num <= n_num; r_den <= n_den; r_neg <= n_neg;
        r_res_num <= n_res_num; r_res_den <= n_res_den; r_status <= n_status;
    end

    `include "rational_arithmetic_unit_top_assert.svh"
    `RAU_ASSERT_IMPL(a_ready_idle, i_clk, i_rst_n, s_axis_tready, !m_axis_tvalid)
    `RAU_ASSERT_IMPL(a_ok_den, i_clk, i_rst_n, m_axis_tvalid && r_status == ST_OK, r_res_den != '0)
    `RAU_ASSERT_NEXT(a_out_done, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready, s_axis_tready)
endmodule

### tb/sv/tb_rational_arithmetic_unit_top.sv
// Testbench of the rational arithmetic unit: directed, back-pressure and random fraction operations.
// Checks every result word against a built-in exact rational predictor.
// Depends on rau_pkg and rational_arithmetic_unit_top.
module tb_rational_arithmetic_unit_top
    import rau_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_status     status;
        logic [30:0] den;
        logic [31:0] num;
    } t_frac_res;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;

    t_frac_res expected_results[$];
    int        error_count;
    int        idle_cycles;
    int        rx_gap = 0;
    bit        allow_idle;
    bit        hold_off;

    rational_arithmetic_unit_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] split_mag(input logic [31:0] raw, output bit neg);
        neg = raw[VALUE_WIDTH-1];
        return neg ? 64'(-$signed(raw)) & 64'hFFFF_FFFF : 64'(raw);
    endfunction

    function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic t_frac_res predict_fraction(input t_kind kind, input logic [31:0] an_r,
            input logic [31:0] ad_r, input logic [31:0] bn_r, input logic [31:0] bd_r);
        t_frac_res   r;
        bit          na, nad, nb, nbd, sa, sb, sbe, neg;
        logic [63:0] an, ad, bn, bd, num, den, g, ta, tb, half;
        an = split_mag(an_r, na);
        ad = split_mag(ad_r, nad);
        bn = split_mag(bn_r, nb);
        bd = split_mag(bd_r, nbd);
        sa = na != nad;
        sb = nb != nbd;
        half = 64'd1 << (VALUE_WIDTH - 1);
        r = '{num: '0, den: '0, status: ST_ZERO};
        if (ad == 0 || bd == 0 || (kind == K_DIV && bn == 0)) return r;
        if (kind == K_ADD || kind == K_SUB) begin
            g = gcd64(ad, bd);
            ta = an * (bd / g);
            tb = bn * (ad / g);
            sbe = (kind == K_SUB) ? !sb : sb;
            den = (ad / g) * bd;
            if (sa == sbe) begin
                num = ta + tb;
                neg = sa;
            end else if (ta >= tb) begin
                num = ta - tb;
                neg = sa;
            end else begin
                num = tb - ta;
                neg = sbe;
            end
        end else if (kind == K_MUL) begin
            num = an * bn;
            den = ad * bd;
            neg = sa != sb;
        end else begin
            num = an * bd;
            den = ad * bn;
            neg = sa != sb;
        end
        if (num == 0) return '{num: '0, den: 31'd1, status: ST_OK};
        g = gcd64(num, den);
        num = num / g;
        den = den / g;
        if (den > half - 1 || (neg ? num > half : num > half - 1)) begin
            r.status = ST_OVF;
            return r;
        end
        r.num = neg ? 32'(-num) : num[31:0];
        r.den = den[30:0];
        r.status = ST_OK;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
            input logic [31:0] want);
        $display("Mismatch on %s: got %0h, expected %0h", field, got, want);
        error_count++;
    endtask

    task automatic send_fraction_pair(input t_kind kind, input logic [31:0] an,
            input logic [31:0] ad, input logic [31:0] bn, input logic [31:0] bd);
        int gap;
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, bd, bn, ad, an, kind};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_results.push_back(predict_fraction(kind, an, ad, bn, bd));
    endtask

    always @(posedge i_clk) begin
        t_frac_res got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[64:0];
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected word", got.num, 32'd0);
            end else begin
                want = expected_results.pop_front();
                if (got.num !== want.num) report_mismatch("res_num", got.num, want.num);
                if (got.den !== want.den) report_mismatch("res_den", got.den, want.den);
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_off) begin
            m_axis_tready <= 1'b0;
        end else if (!allow_idle) begin
            m_axis_tready <= 1'b1;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            m_axis_tready <= (rx_gap == 1);
        end else if ($urandom_range(0, 3) == 0) begin
            m_axis_tready <= 1'b0;
            rx_gap <= $urandom_range(1, 6);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 50000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 16) - 8;
            1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            2: return $urandom_range(1, 1000) * ($urandom_range(0, 1) ? 1 : -1);
            3: return $urandom() >> $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    task automatic test_directed();
        send_fraction_pair(K_ADD, 1, 2, 1, 3);
        send_fraction_pair(K_SUB, 1, 2, 1, 2);
        send_fraction_pair(K_MUL, -3, 4, 2, -9);
        send_fraction_pair(K_DIV, 5, 7, -10, 21);
        send_fraction_pair(K_ADD, 1, 0, 1, 1);
        send_fraction_pair(K_MUL, 1, 1, 1, 0);
        send_fraction_pair(K_DIV, 1, 2, 0, 5);
        send_fraction_pair(K_DIV, 1, 0, 0, 5);
        send_fraction_pair(K_MUL, 0, -7, 5, 3);
        send_fraction_pair(K_ADD, 32'h7FFF_FFFF, 1, 1, 1);
        send_fraction_pair(K_SUB, 32'h8000_0000, 1, 0, 1);
        send_fraction_pair(K_SUB, 32'h8000_0000, 1, 1, 1);
        send_fraction_pair(K_MUL, 32'h8000_0000, 1, 32'hFFFF_FFFF, 1);
        send_fraction_pair(K_DIV, 32'h8000_0000, 1, 1, 32'hFFFF_FFFF);
        send_fraction_pair(K_MUL, 1, 32'h8000_0000, 1, 1);
        send_fraction_pair(K_MUL, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                           32'h7FFF_FFFF);
        send_fraction_pair(K_ADD, 1, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFE);
        send_fraction_pair(K_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1);
        send_fraction_pair(K_SUB, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                           32'h5555_5555);
    endtask

    task automatic test_random(input int count);
        repeat (count)
            send_fraction_pair(t_kind'($urandom_range(0, 3)), pick_value(), pick_value(),
                               pick_value(), pick_value());
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(posedge i_clk);
                hold_off = 1'b0;
            end
            repeat (6)
                send_fraction_pair(t_kind'($urandom_range(0, 3)), $urandom_range(1, 9),
                                   $urandom_range(1, 9), $urandom_range(1, 9),
                                   $urandom_range(1, 9));
        join
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        allow_idle = 1'b1;
        hold_off = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random(1300);
        allow_idle = 1'b0;
        test_random(200);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
